// ===== src/smm_pkg.sv =====
// Shared types and constants for the 4x4 stereo matrix mixer.
// Used by smm_front, smm_queue, smm_back and the top level; no dependencies.
package smm_pkg;

  localparam int unsigned MaxDests   = 4;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned AccW       = 24;
  localparam int unsigned GainW      = 19;
  localparam int unsigned ProdW      = 35;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned InDataW    = 96;
  localparam int unsigned InUserW    = 1;
  localparam int unsigned OutDataW   = 48;
  localparam int unsigned OutUserW   = 3;
  localparam int unsigned LampOffset = 38;
  localparam int unsigned LampMax    = 255;

  // register indexes: mix gains first, modulation depths from this index on
  localparam logic [CfgIdxW-1:0] CfgMixSrc0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDepSrc0 = 3'd4;

  typedef enum logic [1:0] {
    LAMP_OFF = 2'd0,
    LAMP_POS = 2'd1,
    LAMP_NEG = 2'd2
  } lamp_pol_e;

  // one classified source request as it waits for the mixing datapath
  typedef struct packed {
    logic signed [SampleW-1:0]                   left;
    logic signed [SampleW-1:0]                   right;
    logic        [MaxDests-1:0][SampleW-1:0]     mods;
    logic        [1:0]                           src;
    logic                                        fin;
  } item_t;

endpackage

// ===== src/smm_front.sv =====
// Front end: takes source requests, substitutes left for a missing right channel
// and tags each with its source number. Depends on smm_pkg.
module smm_front #(
  parameter int unsigned NUM_SOURCES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [smm_pkg::InDataW-1:0]   in_data_i,
  input  logic [smm_pkg::InUserW-1:0]   in_user_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output smm_pkg::item_t                item_o
);

  logic [1:0] src_q, src_d;
  logic       fin;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign fin        = (src_q == 2'(NUM_SOURCES - 1));

  always_comb begin
    item_o.left  = in_data_i[15:0];
    // reuse left when the right channel is unplugged
    item_o.right = in_user_i[0] ? in_data_i[31:16] : in_data_i[15:0];
    for (int d = 0; d < smm_pkg::MaxDests; d++) begin
      item_o.mods[d] = in_data_i[32 + 16*d +: 16];
    end
    item_o.src = src_q;
    item_o.fin = fin;
  end

  always_comb begin
    src_d = src_q;
    if (push_o) begin
      src_d = fin ? 2'd0 : src_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= 2'd0;
    end else begin
      src_q <= src_d;
    end
  end

endmodule

// ===== src/smm_queue.sv =====
// Two-entry queue between front end and mixing datapath; head always in slot 0.
// Depends on smm_pkg for the item type.
module smm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smm_pkg::item_t push_item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output smm_pkg::item_t head_o
);

  smm_pkg::item_t slot_q [2];
  logic [1:0]     count_q, count_d;
  logic           wr_idx;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[0];
  assign wr_idx       = (count_q == 2'd1) && !pop_i;

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // advance the tail into the head on pop; a push lands behind whatever remains
  always_ff @(posedge clk_i) begin
    if (push_i && !wr_idx) begin
      slot_q[0] <= push_item_i;
    end else if (pop_i) begin
      slot_q[0] <= slot_q[1];
    end
    if (push_i && wr_idx) begin
      slot_q[1] <= push_item_i;
    end
  end

endmodule

// ===== src/smm_back.sv =====
// Mixing datapath (depends on smm_pkg): gain registers, multiply-accumulate stages
// A, B, C stepping one destination per cycle unless stalled, and the output register.
module smm_back #(
  parameter int unsigned NUM_DESTS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [smm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           head_valid_i,
  input  smm_pkg::item_t                 head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [smm_pkg::OutDataW-1:0]   out_data_o,
  output logic [smm_pkg::OutUserW-1:0]   out_user_o,
  output logic                           out_last_o
);

  localparam logic [1:0] LastDest = 2'(NUM_DESTS - 1);

  logic [smm_pkg::CfgDataW-1:0] mix_q [smm_pkg::MaxDests];
  logic [smm_pkg::CfgDataW-1:0] dep_q [smm_pkg::MaxDests];
  logic signed [smm_pkg::AccW-1:0] accl_q [smm_pkg::MaxDests];
  logic signed [smm_pkg::AccW-1:0] accr_q [smm_pkg::MaxDests];

  logic       en;
  logic [1:0] dcnt_q, dcnt_d;
  logic       issue;

  // stage A: depth times modulation
  logic                              va_q;
  logic signed [31:0]                dm_a_q;
  logic signed [15:0]                mix_a_q, l_a_q, r_a_q;
  logic [1:0]                        d_a_q;
  logic                              fin_a_q, last_a_q;
  logic signed [15:0]                dep_sel, mod_sel;
  // stage B: sample times gain
  logic                              vb_q;
  logic signed [smm_pkg::ProdW-1:0]  pl_b_q, pr_b_q;
  logic [1:0]                        d_b_q;
  logic                              fin_b_q, last_b_q;
  logic signed [smm_pkg::GainW-1:0]  gain;
  // stage C: accumulate
  logic                              vc_q;
  logic signed [smm_pkg::AccW-1:0]   accl_c_q, accr_c_q;
  logic [1:0]                        d_c_q;
  logic                              fin_c_q, last_c_q;
  logic signed [smm_pkg::AccW-1:0]   suml, sumr;
  // output stage
  logic                              out_valid_q;
  logic [smm_pkg::OutDataW-1:0]      out_data_q;
  logic [smm_pkg::OutUserW-1:0]      out_user_q;
  logic                              out_last_q;
  logic signed [15:0]                satl, satr;
  logic signed [smm_pkg::AccW:0]     pair;
  logic signed [smm_pkg::AccW-1:0]   avg;
  logic [smm_pkg::AccW-1:0]          mag;
  logic [17:0]                       lvl_raw;
  logic [7:0]                        lvl;
  smm_pkg::lamp_pol_e                pol;

  // whole pipeline holds while a result waits at the output
  assign en    = !out_valid_q || out_ready_i;
  assign issue = en && head_valid_i;
  assign pop_o = issue && (dcnt_q == LastDest);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < smm_pkg::MaxDests; i++) begin
        mix_q[i] <= '0;
        dep_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < smm_pkg::CfgDepSrc0) begin
        mix_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end else begin
        dep_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end
    end
  end

  always_comb begin
    dcnt_d = dcnt_q;
    if (issue) begin
      dcnt_d = (dcnt_q == LastDest) ? 2'd0 : dcnt_q + 2'd1;
    end
  end

  assign dep_sel = dep_q[head_i.src][{dcnt_q, 4'b0000} +: 16];
  assign mod_sel = head_i.mods[dcnt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q      <= 2'd0;
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      dcnt_q <= dcnt_d;
      if (en) begin
        va_q        <= head_valid_i;
        vb_q        <= va_q;
        vc_q        <= vb_q;
        out_valid_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_a_q   <= 32'(dep_sel) * 32'(mod_sel);
      mix_a_q  <= mix_q[head_i.src][{dcnt_q, 4'b0000} +: 16];
      l_a_q    <= head_i.left;
      r_a_q    <= head_i.right;
      d_a_q    <= dcnt_q;
      fin_a_q  <= head_i.fin;
      last_a_q <= (dcnt_q == LastDest);
    end
  end

  assign gain = smm_pkg::GainW'(mix_a_q) + smm_pkg::GainW'(dm_a_q >>> smm_pkg::FracBits);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_b_q   <= smm_pkg::ProdW'(l_a_q) * smm_pkg::ProdW'(gain);
      pr_b_q   <= smm_pkg::ProdW'(r_a_q) * smm_pkg::ProdW'(gain);
      d_b_q    <= d_a_q;
      fin_b_q  <= fin_a_q;
      last_b_q <= last_a_q;
    end
  end

  // floor shift of the product, sign-extended, added with 24-bit wrap
  assign suml = accl_q[d_b_q]
              + smm_pkg::AccW'($signed(pl_b_q[smm_pkg::ProdW-1:smm_pkg::FracBits]));
  assign sumr = accr_q[d_b_q]
              + smm_pkg::AccW'($signed(pr_b_q[smm_pkg::ProdW-1:smm_pkg::FracBits]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < smm_pkg::MaxDests; i++) begin
        accl_q[i] <= '0;
        accr_q[i] <= '0;
      end
    end else if (en && vb_q) begin
      // clear the sums as the last source is added; its totals still go on to stage C
      accl_q[d_b_q] <= fin_b_q ? '0 : suml;
      accr_q[d_b_q] <= fin_b_q ? '0 : sumr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      accl_c_q <= suml;
      accr_c_q <= sumr;
      d_c_q    <= d_b_q;
      fin_c_q  <= fin_b_q;
      last_c_q <= last_b_q;
    end
  end

  always_comb begin
    if (accl_c_q > 24'sd32767) begin
      satl = 16'sh7fff;
    end else if (accl_c_q < -24'sd32768) begin
      satl = -16'sh8000;
    end else begin
      satl = accl_c_q[15:0];
    end
    if (accr_c_q > 24'sd32767) begin
      satr = 16'sh7fff;
    end else if (accr_c_q < -24'sd32768) begin
      satr = -16'sh8000;
    end else begin
      satr = accr_c_q[15:0];
    end
    pair = (smm_pkg::AccW + 1)'(accl_c_q) + (smm_pkg::AccW + 1)'(accr_c_q);
    avg  = pair[smm_pkg::AccW:1];
    mag  = avg[smm_pkg::AccW-1] ? 24'(-avg) : 24'(avg);
    lvl_raw = 18'(mag[smm_pkg::AccW-1:7]) + 18'(smm_pkg::LampOffset);
    if (avg == '0) begin
      pol = smm_pkg::LAMP_OFF;
      lvl = 8'd0;
    end else begin
      pol = avg[smm_pkg::AccW-1] ? smm_pkg::LAMP_NEG : smm_pkg::LAMP_POS;
      lvl = (lvl_raw > 18'(smm_pkg::LampMax)) ? 8'(smm_pkg::LampMax) : lvl_raw[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {6'd0, lvl, pol, satr, satl};
      out_user_q <= {fin_c_q, d_c_q};
      out_last_q <= last_c_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== src/stereo_matrix_mixer_4x4_core.sv =====
// Top level of the 4x4 stereo matrix mixer: front end, request queue and datapath.
// Depends on smm_pkg, smm_front, smm_queue and smm_back.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata: samples, modulation; tuser
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata: sums, lamp; tuser; tlast
//   cfg       in         cfg_we_i (no back-pressure)   cfg_idx_i, cfg_data_i
//
// Each source request gives NUM_DESTS results, one per cycle unless m_axis stalls:
// the datapath has one shared multiply-accumulate path that steps through destinations
// and takes the next request only after the last destination of the current one.
// The first result passes stages A, B, C and the output stage. Reset clears the
// source count, sums and gain registers. A stall at m_axis holds the whole datapath;
// the two-entry queue takes requests until it is full, then s_axis_tready drops.
module stereo_matrix_mixer_4x4_core #(
  parameter int unsigned NUM_SOURCES = 4,
  parameter int unsigned NUM_DESTS   = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // left_sample, right_sample, mod_dest0, mod_dest1, mod_dest2, mod_dest3
  input  logic [smm_pkg::InDataW-1:0]   s_axis_tdata,
  // right_present
  input  logic [smm_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sum_left, sum_right, lamp_polarity, lamp_level, zero fill
  output logic [smm_pkg::OutDataW-1:0]  m_axis_tdata,
  // dest_index, final_sample
  output logic [smm_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [smm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [smm_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic           push, pop, q_full, head_valid;
  smm_pkg::item_t push_item, head;

  smm_front #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  smm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  smm_back #(
    .NUM_DESTS (NUM_DESTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for stereo_matrix_mixer_4x4_core: streams source requests with
// random gaps and stalls and checks every destination result against an in-bench mixer.
// Depends on smm_pkg and the RTL of the mixer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSources = 4;
  localparam int unsigned NumDests   = 4;
  localparam int unsigned LongHold   = 300;
  localparam longint      CycleLimit = 400000;

  typedef struct packed {
    logic [3:0][15:0] mods;
    logic [15:0]      right;
    logic [15:0]      left;
    logic             right_present;
  } src_req_t;

  typedef struct {
    logic [1:0]          dest;
    logic signed [15:0]  sum_l;
    logic signed [15:0]  sum_r;
    smm_pkg::lamp_pol_e  pol;
    logic [7:0]          level;
    logic                fin;
    logic                last;
  } dest_mix_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [smm_pkg::InDataW-1:0]   s_axis_tdata = '0;
  logic [smm_pkg::InUserW-1:0]   s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [smm_pkg::OutDataW-1:0]  m_axis_tdata;
  logic [smm_pkg::OutUserW-1:0]  m_axis_tuser;
  logic                          m_axis_tlast;
  logic                          cfg_we_i = 1'b0;
  logic [smm_pkg::CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [smm_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  // mirror of the gain registers and of the mixing state
  logic [63:0]        mix_gain [4];
  logic [63:0]        mod_depth [4];
  logic signed [23:0] acc_left [4];
  logic signed [23:0] acc_right [4];
  int unsigned        src_count;

  src_req_t  src_backlog [$];
  dest_mix_t mix_expected [$];
  src_req_t  req_on_bus;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_arm = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatch_cnt = 0;
  longint      cycle_cnt = 0;

  stereo_matrix_mixer_4x4_core #(
    .NUM_SOURCES(NumSources),
    .NUM_DESTS  (NumDests)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // mix one source into every destination and queue the four results
  function automatic void mix_source(input src_req_t req);
    int unsigned        s, d;
    logic signed [15:0] lane;
    longint             l, r, mix, dep, md, gain, a, mag, lvl;
    bit                 fin;
    dest_mix_t          res;
    s = src_count;
    l = longint'($signed(req.left));
    r = req.right_present ? longint'($signed(req.right)) : l;
    fin = (s == NumSources - 1);
    for (d = 0; d < NumDests; d++) begin
      lane = mix_gain[s][16*d +: 16];
      mix  = lane;
      lane = mod_depth[s][16*d +: 16];
      dep  = lane;
      lane = req.mods[d];
      md   = lane;
      gain = mix + ((dep * md) >>> smm_pkg::FracBits);
      acc_left[d]  = acc_left[d] + ((l * gain) >>> smm_pkg::FracBits);
      acc_right[d] = acc_right[d] + ((r * gain) >>> smm_pkg::FracBits);
      a = (longint'(acc_left[d]) + longint'(acc_right[d])) >>> 1;
      mag = (a < 0) ? -a : a;
      lvl = (mag >>> 7) + smm_pkg::LampOffset;
      res.dest  = 2'(d);
      res.sum_l = sat16(acc_left[d]);
      res.sum_r = sat16(acc_right[d]);
      res.pol   = (a > 0) ? smm_pkg::LAMP_POS
                          : ((a < 0) ? smm_pkg::LAMP_NEG : smm_pkg::LAMP_OFF);
      res.level = (a == 0) ? 8'd0
                : ((lvl > smm_pkg::LampMax) ? 8'(smm_pkg::LampMax) : 8'(lvl));
      res.fin   = fin;
      res.last  = (d == NumDests - 1);
      mix_expected.push_back(res);
    end
    if (fin) begin
      for (d = 0; d < 4; d++) begin
        acc_left[d]  = '0;
        acc_right[d] = '0;
      end
      src_count = 0;
    end else begin
      src_count = s + 1;
    end
  endfunction

  function automatic void chk_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  // driver: offer the backlog, predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) mix_source(req_on_bus);
      if (src_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_on_bus    <= src_backlog[0];
        s_axis_tdata  <= {src_backlog[0].mods, src_backlog[0].right, src_backlog[0].left};
        s_axis_tuser  <= src_backlog[0].right_present;
        s_axis_tvalid <= 1'b1;
        void'(src_backlog.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check accepted results, drive back-pressure
  always @(posedge clk_i) begin
    dest_mix_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mix_expected.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual tdata %h tuser %h",
                   $realtime, m_axis_tdata, m_axis_tuser);
          mismatch_cnt++;
        end else begin
          exp_r = mix_expected.pop_front();
          chk_field("dest_index", exp_r.dest, m_axis_tuser[1:0]);
          chk_field("sum_left", exp_r.sum_l, $signed(m_axis_tdata[15:0]));
          chk_field("sum_right", exp_r.sum_r, $signed(m_axis_tdata[31:16]));
          chk_field("lamp_polarity", exp_r.pol, m_axis_tdata[33:32]);
          chk_field("lamp_level", exp_r.level, m_axis_tdata[41:34]);
          chk_field("final_sample", exp_r.fin, m_axis_tuser[2]);
          chk_field("last", exp_r.last, m_axis_tlast);
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
        // hold off long enough for the queue to fill and s_axis to stall
        m_axis_tready <= 1'b0;
        hold_left     <= LongHold;
        hold_done     <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_src(input logic [15:0] l, input logic [15:0] r, input logic rp,
                          input logic [15:0] m0, input logic [15:0] m1,
                          input logic [15:0] m2, input logic [15:0] m3);
    src_req_t req;
    req.left          = l;
    req.right         = r;
    req.right_present = rp;
    req.mods          = {m3, m2, m1, m0};
    src_backlog.push_back(req);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 1023)) - 16'd512;
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_mod();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'h7fff;
      3: return 16'h8000;
      4: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  // write registers only with the mixer idle; mirror them at once
  task automatic write_reg(input logic [smm_pkg::CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx < smm_pkg::CfgDepSrc0) mix_gain[idx[1:0]] = val;
    else mod_depth[idx[1:0]] = val;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // fill: 0 random lanes, 1 all lanes at the positive limit, 2 at the negative limit
  task automatic write_all(input int fill);
    int unsigned s, d;
    logic [63:0] mv, dv;
    for (s = 0; s < 4; s++) begin
      for (d = 0; d < 4; d++) begin
        mv[16*d +: 16] = (fill == 1) ? 16'h7fff : ((fill == 2) ? 16'h8000 : pick_gain());
        dv[16*d +: 16] = (fill == 1) ? 16'h7fff : ((fill == 2) ? 16'h8000 : pick_gain());
      end
      write_reg(smm_pkg::CfgMixSrc0 + smm_pkg::CfgIdxW'(s), mv);
      write_reg(smm_pkg::CfgDepSrc0 + smm_pkg::CfgIdxW'(s), dv);
    end
    end_writes();
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (src_backlog.size() != 0 || s_axis_tvalid || mix_expected.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++)
      push_src(pick_sample(), pick_sample(), 1'($urandom), pick_mod(), pick_mod(),
               pick_mod(), pick_mod());
  endtask

  initial begin
    int unsigned s, guard;
    for (s = 0; s < 4; s++) begin
      mix_gain[s]  = '0;
      mod_depth[s] = '0;
      acc_left[s]  = '0;
      acc_right[s] = '0;
    end
    src_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // all gains zero after reset: sums stay zero and lamps stay off
    for (s = 0; s < 4; s++)
      push_src(16'h7fff, 16'h8000, 1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    wait_idle();

    write_reg(smm_pkg::CfgMixSrc0 + 3'd0, {4{16'h4000}});
    write_reg(smm_pkg::CfgMixSrc0 + 3'd1, {4{16'h4000}});
    write_reg(smm_pkg::CfgMixSrc0 + 3'd2, {4{16'h4000}});
    write_reg(smm_pkg::CfgMixSrc0 + 3'd3, {16'h7fff, 16'h8000, 16'hc000, 16'h4000});
    write_reg(smm_pkg::CfgDepSrc0 + 3'd0, {4{16'h7fff}});
    write_reg(smm_pkg::CfgDepSrc0 + 3'd1, {4{16'h8000}});
    write_reg(smm_pkg::CfgDepSrc0 + 3'd2, {16'h2000, 16'he000, 16'h7fff, 16'h8000});
    write_reg(smm_pkg::CfgDepSrc0 + 3'd3, 64'h0);
    end_writes();

    // right absent reuses left; full-scale frame drives the sums into saturation
    for (s = 0; s < 4; s++)
      push_src(16'h7fff, 16'hffff, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (s = 0; s < 4; s++)
      push_src(16'h8000, 16'h7fff, 1'b1, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    // tiny values around zero: lamp off, then the floor of the average goes negative
    push_src(16'h0003, 16'hfffd, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_src(16'hffff, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_src(16'h0001, 16'h0001, 1'b0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    push_src(16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // no idling, with one long receiver hold-off at the start
    write_all(1);
    @(negedge clk_i);
    hold_arm = 1'b1;
    push_random(75);
    wait_idle();

    write_all(0);
    @(negedge clk_i);
    send_idle_pct = 80;
    push_random(75);
    wait_idle();

    write_all(2);
    @(negedge clk_i);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    push_random(75);
    wait_idle();

    write_all(0);
    @(negedge clk_i);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    push_random(75);

    while (src_backlog.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    guard = 0;
    while (mix_expected.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    if (mix_expected.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual none", $realtime,
               mix_expected.size());
      mismatch_cnt += mix_expected.size();
    end
    // drain: catch any stray result after the last one
    repeat (16) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
